// ===== hw/rtl/svam8_pkg.sv =====
// Shared definitions for the eight-lane SIMD vector ALU with multiply-accumulate.
// Holds the opcode and function codes, lane flag type and lane selection helpers.
// No dependencies.
package svam8_pkg;

	localparam int unsigned LANES     = 8;
	localparam int unsigned LANE_W    = 16;
	localparam int unsigned ACC_W     = 48;
	localparam int unsigned ROW_W     = LANES * LANE_W;
	localparam int unsigned VREGS     = 32;
	localparam int unsigned VREG_AW   = 5;

	localparam logic [4:0] OP_MFC2 = 5'd0;
	localparam logic [4:0] OP_CFC2 = 5'd2;
	localparam logic [4:0] OP_MTC2 = 5'd4;
	localparam logic [4:0] OP_CTC2 = 5'd6;

	localparam logic [1:0] SEL_VCO = 2'd0;
	localparam logic [1:0] SEL_VCC = 2'd1;

	localparam logic [5:0] FN_VMULF = 6'h00;
	localparam logic [5:0] FN_VMULU = 6'h04;
	localparam logic [5:0] FN_VMUDM = 6'h05;
	localparam logic [5:0] FN_VMUDN = 6'h06;
	localparam logic [5:0] FN_VMUDH = 6'h07;
	localparam logic [5:0] FN_VMACF = 6'h08;
	localparam logic [5:0] FN_VMADM = 6'h0d;
	localparam logic [5:0] FN_VMADN = 6'h0e;
	localparam logic [5:0] FN_VMADH = 6'h0f;
	localparam logic [5:0] FN_VADD  = 6'h10;
	localparam logic [5:0] FN_VSUB  = 6'h11;
	localparam logic [5:0] FN_VABS  = 6'h13;
	localparam logic [5:0] FN_VADDC = 6'h14;
	localparam logic [5:0] FN_VSUBC = 6'h15;
	localparam logic [5:0] FN_VSAR  = 6'h1d;
	localparam logic [5:0] FN_VGE   = 6'h23;
	localparam logic [5:0] FN_VCL   = 6'h24;
	localparam logic [5:0] FN_VMRG  = 6'h27;
	localparam logic [5:0] FN_VAND  = 6'h28;
	localparam logic [5:0] FN_VNAND = 6'h29;
	localparam logic [5:0] FN_VOR   = 6'h2a;
	localparam logic [5:0] FN_VNOR  = 6'h2b;
	localparam logic [5:0] FN_VXOR  = 6'h2c;
	localparam logic [5:0] FN_VNXOR = 6'h2d;

	localparam logic [3:0] E_SAR_HI  = 4'd8;
	localparam logic [3:0] E_SAR_MID = 4'd9;
	localparam logic [3:0] E_SAR_LO  = 4'd10;

	typedef struct packed {
		logic co;
		logic ne;
		logic cl;
		logic ch;
		logic ce;
	} lane_flags_t;

	function automatic logic fn_known(input logic [5:0] fn);
		logic k;
		case (fn) inside
			FN_VMULF, FN_VMULU, FN_VMUDM, FN_VMUDN, FN_VMUDH, FN_VMACF, FN_VMADM,
			FN_VMADN, FN_VMADH, FN_VADD, FN_VSUB, FN_VABS, FN_VADDC, FN_VSUBC,
			FN_VSAR, FN_VGE, FN_VCL, FN_VMRG, FN_VAND, FN_VNAND, FN_VOR, FN_VNOR,
			FN_VXOR, FN_VNXOR: k = 1'b1;
			default: k = 1'b0;
		endcase
		return k;
	endfunction

	function automatic logic [2:0] pick_lane(input logic [3:0] e, input logic [2:0] i);
		logic [2:0] l;
		if (e < 4'd2) begin
			l = i;
		end else if (e < 4'd4) begin
			l = {i[2:1], e[0]};
		end else if (e < 4'd8) begin
			l = {i[2], e[1:0]};
		end else begin
			l = e[2:0];
		end
		return l;
	endfunction

endpackage

// ===== hw/rtl/svam8_lane.sv =====
// One 16-bit lane of the vector unit: multiply-accumulate, add, compare, clip and logic.
// Depends on svam8_pkg for function codes and the lane flag type.
module svam8_lane (
	input  logic [5:0]                fn,
	input  logic [3:0]                e,
	input  logic [15:0]               s,
	input  logic [15:0]               t,
	input  logic [47:0]               acc,
	input  svam8_pkg::lane_flags_t    flags,
	output logic [15:0]               r,
	output logic [47:0]               acc_new,
	output svam8_pkg::lane_flags_t    flags_new
);
	import svam8_pkg::*;

	logic               sa, sb;
	logic signed [16:0] opa, opb;
	logic signed [33:0] prod;
	logic [47:0]        prod_x, term, base, acc_sum;
	logic               acc_fits;
	logic [15:0]        hi_val, lo_val;
	logic signed [17:0] ss18, tt18, x18;
	logic [16:0]        sum17;
	logic               ge, cl_n, ch_n;

	always_comb begin
		sa = 1'b0;
		sb = 1'b0;
		case (fn) inside
			FN_VMULF, FN_VMUDM, FN_VMUDH, FN_VMACF, FN_VMADM, FN_VMADH: sa = 1'b1;
			default: sa = 1'b0;
		endcase
		case (fn) inside
			FN_VMULF, FN_VMUDN, FN_VMUDH, FN_VMACF, FN_VMADN, FN_VMADH: sb = 1'b1;
			default: sb = 1'b0;
		endcase
	end

	assign opa    = {sa & s[15], s};
	assign opb    = {sb & t[15], t};
	assign prod   = opa * opb;
	assign prod_x = {{14{prod[33]}}, prod};

	always_comb begin
		case (fn) inside
			FN_VMULF, FN_VMACF: term = {prod_x[46:0], 1'b0};
			FN_VMUDH, FN_VMADH: term = {prod_x[31:0], 16'h0000};
			FN_VMULU:           term = {32'h0, prod[31:16]};
			default:            term = prod_x;
		endcase
		case (fn) inside
			FN_VMACF, FN_VMADM, FN_VMADN, FN_VMADH: base = acc;
			FN_VMULF:                               base = 48'h8000;
			default:                                base = '0;
		endcase
	end

	assign acc_sum  = base + term;
	assign acc_fits = (acc_sum[47:31] == {17{acc_sum[47]}});
	assign hi_val   = acc_fits ? acc_sum[31:16] : (acc_sum[47] ? 16'h8000 : 16'h7fff);
	assign lo_val   = acc_fits ? acc_sum[15:0] : (acc_sum[47] ? 16'h0000 : 16'hffff);

	assign ss18  = {{2{s[15]}}, s};
	assign tt18  = {{2{t[15]}}, t};
	assign x18   = (fn == FN_VADD) ? (ss18 + tt18 + 18'(flags.co))
	                               : (ss18 - tt18 - 18'(flags.co));
	assign sum17 = {1'b0, s} + {1'b0, t};
	assign ge    = ($signed(s) > $signed(t)) || ((s == t) && !(flags.ne && flags.co));

	always_comb begin
		cl_n = flags.cl;
		ch_n = flags.ch;
		if (flags.co) begin
			if (!flags.ne) begin
				cl_n = flags.ce ? (sum17 <= 17'h10000) : (sum17 == 17'h0);
			end
		end else begin
			if (!flags.ne) begin
				ch_n = (s >= t);
			end
		end
	end

	always_comb begin
		r         = '0;
		acc_new   = acc;
		flags_new = flags;
		case (fn) inside
			FN_VMULF, FN_VMUDM, FN_VMUDH, FN_VMACF, FN_VMADM, FN_VMADH: begin
				acc_new = acc_sum;
				r       = hi_val;
			end
			FN_VMULU, FN_VMUDN, FN_VMADN: begin
				acc_new = acc_sum;
				r       = lo_val;
			end
			FN_VADD, FN_VSUB: begin
				acc_new      = {acc[47:16], x18[15:0]};
				r            = (x18[17:15] == {3{x18[17]}}) ? x18[15:0]
				               : (x18[17] ? 16'h8000 : 16'h7fff);
				flags_new.co = 1'b0;
				flags_new.ne = 1'b0;
			end
			FN_VADDC: begin
				r            = sum17[15:0];
				acc_new      = {acc[47:16], r};
				flags_new.co = sum17[16];
				flags_new.ne = 1'b0;
			end
			FN_VSUBC: begin
				r            = s - t;
				acc_new      = {acc[47:16], r};
				flags_new.co = (s < t);
				flags_new.ne = (s != t);
			end
			FN_VSAR: begin
				case (e)
					E_SAR_HI:  r = acc[47:32];
					E_SAR_MID: r = acc[31:16];
					E_SAR_LO:  r = acc[15:0];
					default:   r = '0;
				endcase
			end
			FN_VGE: begin
				r            = ge ? s : t;
				acc_new      = {acc[47:16], r};
				flags_new.cl = ge;
				flags_new.ch = 1'b0;
				flags_new.co = 1'b0;
				flags_new.ne = 1'b0;
			end
			FN_VCL: begin
				if (flags.co) begin
					r = cl_n ? (16'h0 - t) : s;
				end else begin
					r = ch_n ? t : s;
				end
				acc_new      = {acc[47:16], r};
				flags_new.cl = cl_n;
				flags_new.ch = ch_n;
				flags_new.co = 1'b0;
				flags_new.ne = 1'b0;
				flags_new.ce = 1'b0;
			end
			FN_VMRG: begin
				r       = flags.cl ? s : t;
				acc_new = {acc[47:16], r};
			end
			FN_VABS: begin
				r       = s[15] ? (16'h0 - t) : ((s == 16'h0) ? 16'h0 : t);
				acc_new = {acc[47:16], r};
			end
			FN_VAND: begin
				r       = s & t;
				acc_new = {acc[47:16], r};
			end
			FN_VNAND: begin
				r       = ~(s & t);
				acc_new = {acc[47:16], r};
			end
			FN_VOR: begin
				r       = s | t;
				acc_new = {acc[47:16], r};
			end
			FN_VNOR: begin
				r       = ~(s | t);
				acc_new = {acc[47:16], r};
			end
			FN_VXOR: begin
				r       = s ^ t;
				acc_new = {acc[47:16], r};
			end
			default: begin
				r       = ~(s ^ t);
				acc_new = {acc[47:16], r};
			end
		endcase
	end

endmodule

// ===== hw/rtl/simd_vector_alu_mac8_unit.sv =====
// Top level of the eight-lane SIMD vector ALU with multiply-accumulate.
// Depends on svam8_pkg and svam8_lane.
//
// Usage: one instruction word enters on the s_ channel with its scalar operand and
// one result word leaves on the m_ channel for every word taken, in order.
// The accepting edge reads the vector register file, a synchronous memory of 32
// rows of eight lanes, at the vs and vt rows; the compute stage then computes all
// eight lanes, and the edge on which it fires writes the destination row back,
// where the word has one, and loads the output register.
// Throughput is one word per cycle unless the receiver stalls; a row written through
// the single write port of the register file by one word is forwarded to the word directly behind it.
// Reset clears the accumulators, the flags and a valid bit per register row, so
// every register reads as zero until written; no clearing pass is needed.
// When the receiver stalls, the output register holds its word, the compute
// stage holds behind it and s_tready falls once both are occupied.
module simd_vector_alu_mac8_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // instruction [31:0], scalar_operand [63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // scalar_result [31:0]
	output logic [1:0]  m_tuser    // scalar_write [0], illegal [1]
);
	import svam8_pkg::*;

	function automatic logic [7:0] row_byte(input logic [ROW_W-1:0] row, input logic [3:0] b);
		return row[{b[3:1], ~b[0], 3'b000} +: 8];
	endfunction

	logic [ROW_W-1:0]   vrf_mem [VREGS];
	logic [VREGS-1:0]   row_valid_q;
	logic [ROW_W-1:0]   rd_a_s1, rd_b_s1;
	logic               va_s1, vb_s1;
	logic [31:0]        insn_s1, sc_s1;
	logic               s1_valid_q;
	logic               adv, fire, accept;
	logic [VREG_AW-1:0] rd_addr_a, rd_addr_b;

	logic [VREG_AW-1:0] fwd_addr_q;
	logic [ROW_W-1:0]   fwd_data_q;
	logic               fwd_valid_q;

	logic [ROW_W-1:0]   row_a, row_b;
	logic [ACC_W-1:0]   acc_q [LANES];
	logic [7:0]         co_q, ne_q, cl_q, ch_q, ce_q;

	logic               is_move, legal;
	logic [4:0]         mv_op;
	logic [3:0]         mv_e, cp_e;
	logic [1:0]         mv_sel;
	logic [5:0]         cp_fn;
	logic [15:0]        flag_word, lane_word;
	logic [31:0]        sres;
	logic               swr, ill;
	logic               wr_en;
	logic [VREG_AW-1:0] wr_addr;
	logic [ROW_W-1:0]   wr_data, mt_row, res_row;
	logic [4:0]         e_next;

	logic [15:0]        lane_r   [LANES];
	logic [ACC_W-1:0]   lane_acc [LANES];
	lane_flags_t        lane_fi  [LANES];
	lane_flags_t        lane_fo  [LANES];

	logic               out_valid_q, out_swr_q, out_ill_q;
	logic [31:0]        out_sres_q;

	assign adv      = !out_valid_q || m_tready;
	assign fire     = s1_valid_q && adv;
	assign s_tready = !s1_valid_q || adv;
	assign accept   = s_tvalid && s_tready;

	assign rd_addr_a = s_tdata[15:11];
	assign rd_addr_b = s_tdata[20:16];

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_a_s1 <= vrf_mem[rd_addr_a];
			rd_b_s1 <= vrf_mem[rd_addr_b];
			va_s1   <= row_valid_q[rd_addr_a];
			vb_s1   <= row_valid_q[rd_addr_b];
			insn_s1 <= s_tdata[31:0];
			sc_s1   <= s_tdata[63:32];
		end
		if (wr_en) begin
			vrf_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			row_valid_q <= '0;
			fwd_valid_q <= 1'b0;
			fwd_addr_q  <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
				fwd_valid_q          <= 1'b1;
				fwd_addr_q           <= wr_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_data_q <= wr_data;
		end
	end

	assign row_a = (fwd_valid_q && fwd_addr_q == insn_s1[15:11]) ? fwd_data_q
	             : (va_s1 ? rd_a_s1 : '0);
	assign row_b = (fwd_valid_q && fwd_addr_q == insn_s1[20:16]) ? fwd_data_q
	             : (vb_s1 ? rd_b_s1 : '0);

	assign is_move = !insn_s1[25];
	assign mv_op   = insn_s1[25:21];
	assign mv_e    = insn_s1[10:7];
	assign mv_sel  = insn_s1[12:11];
	assign cp_e    = insn_s1[24:21];
	assign cp_fn   = insn_s1[5:0];
	assign e_next  = {1'b0, mv_e} + 5'd1;

	generate
		for (genvar i = 0; i < LANES; i++) begin : g_lane
			assign lane_fi[i] = '{co: co_q[i], ne: ne_q[i], cl: cl_q[i], ch: ch_q[i],
			                      ce: ce_q[i]};
			svam8_lane u_lane (
				.fn        (cp_fn),
				.e         (cp_e),
				.s         (row_a[i*LANE_W +: LANE_W]),
				.t         (row_b[pick_lane(cp_e, 3'(i))*LANE_W +: LANE_W]),
				.acc       (acc_q[i]),
				.flags     (lane_fi[i]),
				.r         (lane_r[i]),
				.acc_new   (lane_acc[i]),
				.flags_new (lane_fo[i])
			);
			assign res_row[i*LANE_W +: LANE_W] = lane_r[i];
		end
	endgenerate

	always_comb begin
		for (int b = 0; b < 16; b++) begin
			if (mv_e == 4'(b)) begin
				mt_row[b[3:1]*16 + (b[0] ? 0 : 8) +: 8] = sc_s1[15:8];
			end else if (e_next == 5'(b) && mv_e != 4'd15) begin
				mt_row[b[3:1]*16 + (b[0] ? 0 : 8) +: 8] = sc_s1[7:0];
			end else begin
				mt_row[b[3:1]*16 + (b[0] ? 0 : 8) +: 8] = row_byte(row_a, 4'(b));
			end
		end
	end

	always_comb begin
		unique case (mv_sel)
			SEL_VCO: flag_word = {ne_q, co_q};
			SEL_VCC: flag_word = {ch_q, cl_q};
			default: flag_word = {8'h00, ce_q};
		endcase
		lane_word = {row_byte(row_a, mv_e), row_byte(row_a, e_next[3:0])};
	end

	always_comb begin
		sres    = '0;
		swr     = 1'b0;
		ill     = 1'b0;
		legal   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = insn_s1[10:6];
		wr_data = res_row;
		if (is_move) begin
			wr_addr = insn_s1[15:11];
			wr_data = mt_row;
			unique case (mv_op)
				OP_MFC2: begin
					sres = {{16{lane_word[15]}}, lane_word};
					swr  = 1'b1;
				end
				OP_CFC2: begin
					sres = {{16{flag_word[15]}}, flag_word};
					swr  = 1'b1;
				end
				OP_MTC2: wr_en = fire;
				OP_CTC2: legal = 1'b1;
				default: ill = 1'b1;
			endcase
		end else if (fn_known(cp_fn)) begin
			legal = 1'b1;
			wr_en = fire;
		end else begin
			ill = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++) begin
				acc_q[i] <= '0;
			end
			co_q <= '0;
			ne_q <= '0;
			cl_q <= '0;
			ch_q <= '0;
			ce_q <= '0;
		end else if (fire && legal) begin
			if (is_move) begin
				unique case (mv_sel)
					SEL_VCO: begin
						co_q <= sc_s1[7:0];
						ne_q <= sc_s1[15:8];
					end
					SEL_VCC: begin
						cl_q <= sc_s1[7:0];
						ch_q <= sc_s1[15:8];
					end
					default: ce_q <= sc_s1[7:0];
				endcase
			end else begin
				for (int i = 0; i < LANES; i++) begin
					acc_q[i] <= lane_acc[i];
					co_q[i]  <= lane_fo[i].co;
					ne_q[i]  <= lane_fo[i].ne;
					cl_q[i]  <= lane_fo[i].cl;
					ch_q[i]  <= lane_fo[i].ch;
					ce_q[i]  <= lane_fo[i].ce;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_sres_q <= sres;
			out_swr_q  <= swr;
			out_ill_q  <= ill;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sres_q;
	assign m_tuser  = {out_ill_q, out_swr_q};

`ifndef SYNTH
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !adv) |-> !s_tready)
		else $error("Word accepted while the compute stage was blocked.");

	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid)
		else $error("Computed word did not reach the output register.");

	a_illegal_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && ill) |-> (!wr_en && !legal && !swr))
		else $error("Unimplemented opcode changed state or wrote a scalar.");
`endif

endmodule
